// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the indexed deque buffer RTL.
// Needs signals named clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every rising clock edge out of reset
`define IDB_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// same-cycle implication
`define IDB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IDB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/idb_pkg.sv
// Package for the indexed deque buffer: defaults, operation and status codes,
// controller-to-datapath command struct. No dependencies.
`default_nettype none

package idb_pkg;

    localparam int unsigned DEPTH_DEFAULT      = 64;
    localparam int unsigned WORD_WIDTH_DEFAULT = 32;
    localparam int unsigned POS_W_DEFAULT      = $clog2(DEPTH_DEFAULT);
    localparam int unsigned LEN_W_DEFAULT      = $clog2(DEPTH_DEFAULT + 1);
    localparam int unsigned OP_W               = 3;
    localparam int unsigned STATUS_W           = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ       = 3'd4,
        OP_WRITE      = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic capture;  // load request transaction into datapath
        logic execute;  // ring access and pointer update
    } ctrl_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/idb_if.sv
// Request and response channel interfaces of the indexed deque buffer.
// Depends on idb_pkg for default widths.
`default_nettype none

interface idb_req_if #(
    parameter int unsigned POS_W      = idb_pkg::POS_W_DEFAULT,
    parameter int unsigned WORD_WIDTH = idb_pkg::WORD_WIDTH_DEFAULT
);
    logic                               valid;
    logic                               ready;
    logic [idb_pkg::OP_W-1:0]           operation;
    logic [POS_W-1:0]                   position;
    logic signed [WORD_WIDTH-1:0]       word_in;

    modport source (output valid, output operation, output position, output word_in,
                    input ready);
    modport sink   (input valid, input operation, input position, input word_in,
                    output ready);
endinterface

interface idb_rsp_if #(
    parameter int unsigned LEN_W      = idb_pkg::LEN_W_DEFAULT,
    parameter int unsigned WORD_WIDTH = idb_pkg::WORD_WIDTH_DEFAULT
);
    logic                               valid;
    logic                               ready;
    logic signed [WORD_WIDTH-1:0]       word_out;
    logic [LEN_W-1:0]                   length;
    logic [idb_pkg::STATUS_W-1:0]       status;

    modport source (output valid, output word_out, output length, output status,
                    input ready);
    modport sink   (input valid, input word_out, input length, input status,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/idb_ctrl.sv
// Controller of the indexed deque buffer: one-hot FSM for accept, access, respond.
// Depends on idb_pkg and assert_macros.svh.
`default_nettype none

module idb_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      idb_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_ACCESS  = 3'b010,
        ST_RESPOND = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                state_next = ST_RESPOND;
            end
            ST_RESPOND:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_RESPOND);
    assign cmd.capture = in_valid && in_ready;
    assign cmd.execute = (state_reg == ST_ACCESS);

`include "assert_macros.svh"

    `IDB_ASSERT(a_no_overlap, !(in_ready && out_valid), "accept open while response pending")
    `IDB_ASSERT_NXT(a_capture_exec, cmd.capture, cmd.execute, "capture not followed by access")
    `IDB_ASSERT_NXT(a_exec_resp, cmd.execute, out_valid, "access not followed by response")

endmodule

`default_nettype wire

// File: hw/rtl/idb_dp.sv
// Datapath of the indexed deque buffer: request registers, head and count,
// ring memory and response registers. Depends on idb_pkg and assert_macros.svh.
`default_nettype none

module idb_dp #(
    parameter int unsigned DEPTH      = idb_pkg::DEPTH_DEFAULT,
    parameter int unsigned WORD_WIDTH = idb_pkg::WORD_WIDTH_DEFAULT,
    parameter int unsigned POS_W      = $clog2(DEPTH),
    parameter int unsigned LEN_W      = $clog2(DEPTH + 1)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire idb_pkg::ctrl_cmd_t             cmd,
    input  wire logic [idb_pkg::OP_W-1:0]       operation,
    input  wire logic [POS_W-1:0]               position,
    input  wire logic signed [WORD_WIDTH-1:0]   word_in,
    output      logic signed [WORD_WIDTH-1:0]   word_out,
    output      logic [LEN_W-1:0]               length,
    output      logic [idb_pkg::STATUS_W-1:0]   status
);

    localparam logic [POS_W-1:0] LAST_SLOT = POS_W'(DEPTH - 1);
    localparam logic [POS_W:0]   DEPTH_EXT = (POS_W + 1)'(DEPTH);
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(DEPTH);

    logic [idb_pkg::OP_W-1:0]   op_reg;
    logic [POS_W-1:0]           pos_reg;
    logic [WORD_WIDTH-1:0]      word_reg;

    logic [POS_W-1:0]           head_reg;
    logic [POS_W-1:0]           head_next;
    logic [LEN_W-1:0]           count_reg;
    logic [LEN_W-1:0]           count_next;
    idb_pkg::status_t           status_reg;
    idb_pkg::status_t           status_next;
    logic                       rd_sel_reg;
    logic [WORD_WIDTH-1:0]      rd_data_reg;

    logic [WORD_WIDTH-1:0]      ring_mem [DEPTH];

    logic [POS_W-1:0]           head_dec;
    logic [POS_W-1:0]           head_inc;
    logic [LEN_W-1:0]           count_dec;
    logic [POS_W-1:0]           offset;
    logic [POS_W:0]             slot_sum;
    logic [POS_W:0]             slot_wrap;
    logic [POS_W-1:0]           slot;
    logic                       is_full;
    logic                       is_empty;
    logic                       out_of_range;
    logic                       mem_we;
    logic                       mem_re;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= operation;
            pos_reg  <= position;
            word_reg <= word_in;
        end
    end

    assign head_dec     = (head_reg == '0) ? LAST_SLOT : head_reg - POS_W'(1);
    assign head_inc     = (head_reg == LAST_SLOT) ? '0 : head_reg + POS_W'(1);
    assign count_dec    = count_reg - LEN_W'(1);
    assign is_full      = (count_reg == DEPTH_LEN);
    assign is_empty     = (count_reg == '0);
    assign out_of_range = (LEN_W'(pos_reg) >= count_reg);

    always_comb
    begin
        offset = '0;
        unique case (op_reg)
            idb_pkg::OP_PUSH_BACK:  offset = count_reg[POS_W-1:0];
            idb_pkg::OP_POP_BACK:   offset = count_dec[POS_W-1:0];
            idb_pkg::OP_READ,
            idb_pkg::OP_WRITE:      offset = pos_reg;
            default:                offset = '0;
        endcase
    end

    assign slot_sum  = {1'b0, head_reg} + {1'b0, offset};
    assign slot_wrap = (slot_sum >= DEPTH_EXT) ? slot_sum - DEPTH_EXT : slot_sum;
    assign slot      = (op_reg == idb_pkg::OP_PUSH_FRONT) ? head_dec : slot_wrap[POS_W-1:0];

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = idb_pkg::ST_OK;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        unique case (op_reg)
            idb_pkg::OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status_next = idb_pkg::ST_FULL;
                end
                else
                begin
                    head_next  = head_dec;
                    count_next = count_reg + LEN_W'(1);
                    mem_we     = 1'b1;
                end
            end
            idb_pkg::OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = idb_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + LEN_W'(1);
                    mem_we     = 1'b1;
                end
            end
            idb_pkg::OP_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = idb_pkg::ST_EMPTY;
                end
                else
                begin
                    head_next  = head_inc;
                    count_next = count_dec;
                    mem_re     = 1'b1;
                end
            end
            idb_pkg::OP_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = idb_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_dec;
                    mem_re     = 1'b1;
                end
            end
            idb_pkg::OP_READ:
            begin
                if (out_of_range)
                begin
                    status_next = idb_pkg::ST_RANGE;
                end
                else
                begin
                    mem_re = 1'b1;
                end
            end
            idb_pkg::OP_WRITE:
            begin
                if (out_of_range)
                begin
                    status_next = idb_pkg::ST_RANGE;
                end
                else
                begin
                    mem_we = 1'b1;
                end
            end
            default:
            begin
                status_next = idb_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            status_reg <= idb_pkg::ST_OK;
            rd_sel_reg <= 1'b0;
        end
        else if (cmd.execute)
        begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            rd_sel_reg <= mem_re;
        end
    end

    // ring memory, one port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.execute && mem_we)
        begin
            ring_mem[slot] <= word_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && mem_re)
        begin
            rd_data_reg <= ring_mem[slot];
        end
    end

    assign word_out = rd_sel_reg ? $signed(rd_data_reg) : '0;
    assign length   = count_reg;
    assign status   = status_reg;

`include "assert_macros.svh"

    `IDB_ASSERT(a_count_max, count_reg <= DEPTH_LEN, "element count above capacity")
    `IDB_ASSERT(a_head_range, {1'b0, head_reg} < DEPTH_EXT, "head pointer outside ring")
    `IDB_ASSERT_IMP(a_fail_holds, $past(cmd.execute) && (status_reg != idb_pkg::ST_OK),
        (count_reg == $past(count_reg)) && (head_reg == $past(head_reg)),
        "failed request changed pointers")

endmodule

`default_nettype wire

// File: hw/rtl/indexed_deque_buffer_top.sv
// Top level of the indexed deque buffer: controller plus datapath.
// Depends on idb_pkg, idb_if, idb_ctrl, idb_dp.
//
//   channel  modport  direction  payload
//   req      sink     in         operation, position, word_in
//   rsp      source   out        word_out, length, status
//
// Each request transaction goes through accept, one ring memory access
// (single-port read or write plus head/count update), then the response.
// The next request is accepted in the cycle after the response transaction.
// Reset clears head, count, status and read select; ring contents are undefined until written.
// A stalled response holds the block; req.ready stays low until it is taken.
`default_nettype none

module indexed_deque_buffer_top #(
    parameter int unsigned DEPTH      = idb_pkg::DEPTH_DEFAULT,
    parameter int unsigned WORD_WIDTH = idb_pkg::WORD_WIDTH_DEFAULT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    idb_req_if.sink     req,
    idb_rsp_if.source   rsp
);

    localparam int unsigned POS_W = $clog2(DEPTH);
    localparam int unsigned LEN_W = $clog2(DEPTH + 1);

    idb_pkg::ctrl_cmd_t cmd;
    logic               in_ready;
    logic               out_valid;

    idb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    idb_dp #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH),
        .POS_W      (POS_W),
        .LEN_W      (LEN_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .operation (req.operation),
        .position  (req.position),
        .word_in   (req.word_in),
        .word_out  (rsp.word_out),
        .length    (rsp.length),
        .status    (rsp.status)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

endmodule

`default_nettype wire

// File: sim/idb_checker.sv
`timescale 1ns / 1ps
// Response checker for the indexed deque buffer: keeps a shadow deque, predicts each
// response from the accepted requests and compares it field by field.
// Depends on idb_pkg and the idb_req_if / idb_rsp_if channel interfaces.
module idb_checker (
    input  logic clk,
    input  logic rst_n,
    idb_req_if   req,
    idb_rsp_if   rsp,
    output int   mismatches,
    output int   outstanding,
    output int   ok_count,
    output int   empty_count,
    output int   full_count,
    output int   range_count,
    output int   peak_length
);
    import idb_pkg::*;

    localparam int DEPTH  = DEPTH_DEFAULT;
    localparam int WORD_W = WORD_WIDTH_DEFAULT;
    localparam int POS_W  = POS_W_DEFAULT;
    localparam int LEN_W  = LEN_W_DEFAULT;

    typedef struct packed {
        logic signed [WORD_W-1:0] word;
        logic [LEN_W-1:0]         length;
        status_t                  status;
    } deque_reply_t;

    logic signed [WORD_W-1:0] shadow_ring [DEPTH];
    logic [POS_W-1:0]         shadow_head;
    logic [LEN_W-1:0]         shadow_count;
    deque_reply_t             replies_due [$];

    function automatic deque_reply_t apply_request(logic [OP_W-1:0] op,
                                                   logic [POS_W-1:0] pos,
                                                   logic signed [WORD_W-1:0] word);
        deque_reply_t     r;
        logic [POS_W-1:0] slot;
        r.word   = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH_FRONT:
                if (shadow_count == LEN_W'(DEPTH))
                    r.status = ST_FULL;
                else
                begin
                    shadow_head = shadow_head - 1'b1;
                    shadow_ring[shadow_head] = word;
                    shadow_count = shadow_count + 1'b1;
                end
            OP_PUSH_BACK:
                if (shadow_count == LEN_W'(DEPTH))
                    r.status = ST_FULL;
                else
                begin
                    slot = shadow_head + shadow_count[POS_W-1:0];
                    shadow_ring[slot] = word;
                    shadow_count = shadow_count + 1'b1;
                end
            OP_POP_FRONT:
                if (shadow_count == '0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.word = shadow_ring[shadow_head];
                    shadow_head = shadow_head + 1'b1;
                    shadow_count = shadow_count - 1'b1;
                end
            OP_POP_BACK:
                if (shadow_count == '0)
                    r.status = ST_EMPTY;
                else
                begin
                    slot = shadow_head + POS_W'(shadow_count - 1'b1);
                    r.word = shadow_ring[slot];
                    shadow_count = shadow_count - 1'b1;
                end
            OP_READ:
                if ({1'b0, pos} >= shadow_count)
                    r.status = ST_RANGE;
                else
                begin
                    slot = shadow_head + pos;
                    r.word = shadow_ring[slot];
                end
            OP_WRITE:
                if ({1'b0, pos} >= shadow_count)
                    r.status = ST_RANGE;
                else
                begin
                    slot = shadow_head + pos;
                    shadow_ring[slot] = word;
                end
            default:
            begin
            end
        endcase
        r.length = shadow_count;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        deque_reply_t due;
        if (!rst_n)
        begin
            shadow_head  = '0;
            shadow_count = '0;
            replies_due.delete();
            outstanding  = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (replies_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: response with no request pending: word %0d length %0d status %0d",
                                 $realtime, rsp.word_out, rsp.length, rsp.status);
                end
                else
                begin
                    due = replies_due.pop_front();
                    if (rsp.word_out !== due.word || rsp.length !== due.length
                        || rsp.status !== due.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: expected word %0d length %0d status %0d, got word %0d length %0d status %0d",
                                     $realtime, due.word, due.length, due.status,
                                     rsp.word_out, rsp.length, rsp.status);
                    end
                    case (due.status)
                        ST_OK:    ok_count++;
                        ST_EMPTY: empty_count++;
                        ST_FULL:  full_count++;
                        ST_RANGE: range_count++;
                        default:
                        begin
                        end
                    endcase
                    if (int'(due.length) > peak_length)
                        peak_length = int'(due.length);
                end
            end
            if (req.valid && req.ready)
                replies_due.push_back(apply_request(req.operation, req.position, req.word_in));
            outstanding = replies_due.size();
        end
    end

endmodule

// File: sim/indexed_deque_buffer_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the indexed deque buffer: clock, reset, request stimulus and
// response back-pressure. Depends on idb_pkg, idb_if, idb_checker and the RTL top.
module indexed_deque_buffer_top_tb;
    import idb_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam int DEPTH          = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS   = 1250;
    localparam int TAIL_ITEMS     = 150;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_CYCLES   = 20;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED, PH_ACCESS} phase_t;

    logic clk = 1'b0;
    logic rst_n;

    int mismatches;
    int outstanding;
    int ok_count;
    int empty_count;
    int full_count;
    int range_count;
    int peak_length;

    int fill_level;
    int items_sent;
    int random_sent;
    int idle_cycles = 0;
    bit send_gaps;
    bit recv_stalls;

    idb_req_if req_ch ();
    idb_rsp_if rsp_ch ();

    indexed_deque_buffer_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    idb_checker deque_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .ok_count    (ok_count),
        .empty_count (empty_count),
        .full_count  (full_count),
        .range_count (range_count),
        .peak_length (peak_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic [OP_W-1:0] op, logic [POS_W_DEFAULT-1:0] pos,
                             logic signed [WORD_WIDTH_DEFAULT-1:0] word);
        int gap;
        if (send_gaps && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.operation = op;
        req_ch.position  = pos;
        req_ch.word_in   = word;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
                if (fill_level < DEPTH)
                    fill_level++;
            OP_POP_FRONT, OP_POP_BACK:
                if (fill_level > 0)
                    fill_level--;
            default:
            begin
            end
        endcase
        items_sent++;
    endtask

    function automatic logic signed [WORD_WIDTH_DEFAULT-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W_DEFAULT-1:0] pick_pos();
        if (fill_level > 0 && $urandom_range(0, 4) != 0)
            return POS_W_DEFAULT'($urandom_range(0, fill_level - 1));
        return POS_W_DEFAULT'($urandom_range(0, DEPTH - 1));
    endfunction

    function automatic logic [OP_W-1:0] any_op();
        int roll;
        roll = $urandom_range(0, 40);
        if (roll == 40)
            return $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
        return op_t'(roll % 6);
    endfunction

    task automatic random_item(phase_t ph);
        int              roll;
        logic [OP_W-1:0] op;
        roll = $urandom_range(0, 99);
        case (ph)
            PH_FILL:
                op = (roll < 85) ? ($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK)
                                 : any_op();
            PH_DRAIN:
                op = (roll < 85) ? ($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK)
                                 : any_op();
            PH_ACCESS:
                op = (roll < 80) ? ($urandom_range(0, 1) ? OP_READ : OP_WRITE) : any_op();
            default:
                op = any_op();
        endcase
        send_item(op, pick_pos(), pick_word());
        random_sent++;
    endtask

    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (recv_stalls && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        phase_t ph;
        int     span;
        int     n;
        int     extra;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_PUSH_FRONT;
        req_ch.position  = '0;
        req_ch.word_in   = '0;
        fill_level       = 0;
        items_sent       = 0;
        random_sent      = 0;
        send_gaps        = 1'b0;
        recv_stalls      = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty errors, spare codes, extremes, wrap at the front, range errors
        send_item(OP_POP_FRONT, '0, '0);
        send_item(OP_POP_BACK, '0, '0);
        send_item(OP_READ, 6'd0, '0);
        send_item(OP_WRITE, 6'd63, '1);
        send_item(OP_SPARE_LO, 6'd63, '1);
        send_item(OP_SPARE_HI, '0, '0);
        send_item(OP_PUSH_BACK, '0, 32'sh7FFF_FFFF);
        send_item(OP_PUSH_FRONT, 6'd63, 32'sh8000_0000);
        send_item(OP_PUSH_BACK, '0, '1);
        send_item(OP_PUSH_FRONT, '0, '0);
        send_item(OP_READ, 6'd0, '0);
        send_item(OP_READ, 6'd3, '0);
        send_item(OP_READ, 6'd4, '0);
        send_item(OP_WRITE, 6'd1, 32'sh5555_5555);
        send_item(OP_READ, 6'd1, '0);
        send_item(OP_WRITE, 6'd3, 32'shAAAA_AAAA);
        send_item(OP_WRITE, 6'd63, '0);
        send_item(OP_POP_BACK, '0, '0);
        send_item(OP_POP_FRONT, '0, '0);
        send_item(OP_POP_FRONT, '0, '0);
        send_item(OP_POP_BACK, '0, '0);
        send_item(OP_POP_FRONT, '0, '0);

        while (random_sent < RANDOM_ITEMS)
        begin
            ph = phase_t'($urandom_range(0, 3));
            if (random_sent >= RANDOM_ITEMS - TAIL_ITEMS)
            begin
                send_gaps   = 1'b0;
                recv_stalls = 1'b0;
            end
            else
            begin
                send_gaps   = $urandom_range(0, 3) != 0;
                recv_stalls = $urandom_range(0, 3) != 0;
            end
            span  = $urandom_range(20, 80);
            n     = 0;
            extra = 0;
            while (random_sent < RANDOM_ITEMS && n < 200
                   && (ph == PH_FILL || ph == PH_DRAIN ? extra < 4 : n < span))
            begin
                if ((ph == PH_FILL && fill_level == DEPTH) || (ph == PH_DRAIN && fill_level == 0))
                    extra++;
                random_item(ph);
                n++;
            end
        end
        req_ch.valid = 1'b0;

        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d requests; results ok %0d, empty %0d, full %0d, out of range %0d",
                 items_sent, ok_count, empty_count, full_count, range_count);
        $display("peak deque length %0d of %0d, %0d mismatching responses",
                 peak_length, DEPTH, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
